// ----- hw/rtl/orbcam_pkg.sv -----
// Orbit camera package: command codes, register indexes, controller-to-datapath
// command struct, fixed constants and the elaboration-time quarter-wave sine table
// generator. No dependencies.
package orbcam_pkg;

  typedef enum logic [1:0] {
    OP_REL  = 2'd0,
    OP_ABS  = 2'd1,
    OP_DIST = 2'd2,
    OP_HOME = 2'd3
  } orbcam_op_e;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } orbcam_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_FACT,
    S_SCALE,
    S_SUM
  } orbcam_state_e;

  typedef struct packed {
    logic accept;   // latch the command and update the view state
    logic look;     // register the four sine/cosine values
    logic fact;     // register the horizontal factors
    logic scale;    // register the distance products
    logic load;     // write the result into the output register
  } orbcam_cmd_t;

  localparam int ELEV_LIMIT = 16280;
  localparam logic [15:0] HOME_AZIMUTH = 16'd40960;
  localparam logic signed [15:0] HOME_ELEVATION = -16'sd3277;
  localparam logic [23:0] HOME_DISTANCE = 24'd1024;
  localparam logic [21:0] RADIUS_RESET = 22'd256;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // One entry of the quarter-wave table (Q16), from a Q30 Taylor series.
  function automatic logic [16:0] qsin_entry(int unsigned k, int unsigned tb);
    longint x;
    longint x2;
    longint term;
    longint sum;
    x = (longint'(k) * HALF_PI_Q30) >>> (tb - 2);
    x2 = (x * x) >>> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >>> 30;
      case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        6: term = term / 156;
        default: term = term / 210;
      endcase
      if ((n % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    sum = (sum + 64'sd8192) >>> 14;
    return sum[16:0];
  endfunction

endpackage

// ----- hw/rtl/orbcam_if.sv -----
// Orbit camera channel interfaces: command channel and position channel,
// each with valid/ready handshake. No dependencies.
interface orbcam_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [11:0] delta_x;
  logic signed [11:0] delta_y;
  logic [15:0]        new_azimuth;
  logic signed [15:0] new_elevation;
  logic [23:0]        new_distance;

  modport source (output valid, cmd, delta_x, delta_y, new_azimuth, new_elevation,
                  new_distance, input ready);
  modport sink (input valid, cmd, delta_x, delta_y, new_azimuth, new_elevation,
                new_distance, output ready);
endinterface

interface orbcam_pos_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [15:0]        cur_azimuth;
  logic signed [15:0] cur_elevation;
  logic [23:0]        cur_distance;

  modport source (output valid, pos_x, pos_y, pos_z, cur_azimuth, cur_elevation,
                  cur_distance, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, cur_azimuth, cur_elevation,
                cur_distance, output ready);
endinterface

// ----- hw/rtl/orbit_camera_position.sv -----
// Orbit camera position top level: controller plus datapath.
// Depends on orbcam_pkg, orbcam_if, orbcam_ctrl and orbcam_dp.
//
// Usage:
//   cmd_i carries one camera command per transaction (relative move, absolute
//   move, set distance, home view). pos_o returns one transaction per command:
//   the camera position around the orbit center and the updated view angles.
//   The cfg_* port writes the orbit center and the scene bounding radius; write
//   it only while no command is in flight.
//   The command passes through the lookup, factor, scale and sum steps, and
//   the result enters the output register when the output is free. A new
//   command is taken only after the accept step and the controller's walk
//   through lookup, factor, scale and sum.
//   cmd_i.ready is high only while the controller is idle; a finished result
//   may still wait in the output register while the next command is taken.
//   If the receiver stalls, the output holds and the next result waits in the
//   sum step until the output register drains.
//   Reset: view returns to the home angles with distance 1024, center 0 and
//   bounding radius 256; no transaction is pending on either channel.
module orbit_camera_position #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int STEP_PER_PIXEL  = 104
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  orbcam_cmd_if.sink  cmd_i,
  orbcam_pos_if.source pos_o
);

  orbcam_pkg::orbcam_cmd_t cmd;

  orbcam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (pos_o.valid),
    .out_ready_i (pos_o.ready),
    .cmd_o       (cmd)
  );

  orbcam_dp #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .STEP_PER_PIXEL  (STEP_PER_PIXEL)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_i            (cmd_i.cmd),
    .delta_x_i       (cmd_i.delta_x),
    .delta_y_i       (cmd_i.delta_y),
    .new_azimuth_i   (cmd_i.new_azimuth),
    .new_elevation_i (cmd_i.new_elevation),
    .new_distance_i  (cmd_i.new_distance),
    .pos_x_o         (pos_o.pos_x),
    .pos_y_o         (pos_o.pos_y),
    .pos_z_o         (pos_o.pos_z),
    .cur_azimuth_o   (pos_o.cur_azimuth),
    .cur_elevation_o (pos_o.cur_elevation),
    .cur_distance_o  (pos_o.cur_distance)
  );

endmodule

// ----- hw/rtl/orbcam_ctrl.sv -----
// Orbit camera controller: sequences lookup, factor, scale and sum steps and
// owns the output valid flag. Depends on orbcam_pkg.
module orbcam_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output orbcam_pkg::orbcam_cmd_t cmd_o
);

  orbcam_pkg::orbcam_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= orbcam_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      orbcam_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = orbcam_pkg::S_LOOK;
        end
      end
      orbcam_pkg::S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d = orbcam_pkg::S_FACT;
      end
      orbcam_pkg::S_FACT: begin
        cmd_o.fact = 1'b1;
        state_d = orbcam_pkg::S_SCALE;
      end
      orbcam_pkg::S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = orbcam_pkg::S_SUM;
      end
      orbcam_pkg::S_SUM: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d = orbcam_pkg::S_IDLE;
        end
      end
      default: state_d = orbcam_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/orbcam_dp.sv -----
// Orbit camera datapath: view state, configuration registers, sine table
// lookups, multipliers, rounding and saturation. Depends on orbcam_pkg.
module orbcam_dp #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int STEP_PER_PIXEL  = 104
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  orbcam_pkg::orbcam_cmd_t cmd_i,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [31:0]             cfg_wdata_i,
  input  logic [1:0]              op_i,
  input  logic signed [11:0]      delta_x_i,
  input  logic signed [11:0]      delta_y_i,
  input  logic [15:0]             new_azimuth_i,
  input  logic signed [15:0]      new_elevation_i,
  input  logic [23:0]             new_distance_i,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      pos_z_o,
  output logic [15:0]             cur_azimuth_o,
  output logic signed [15:0]      cur_elevation_o,
  output logic [23:0]             cur_distance_o
);

  localparam int QE     = 1 << (SINE_TABLE_BITS - 2);
  localparam int TIW    = SINE_TABLE_BITS - 1;
  localparam int STEP_W = $clog2(STEP_PER_PIXEL + 1) + 1;
  localparam int MW     = 12 + STEP_W;
  localparam int EW     = ((MW > 16) ? MW : 16) + 1;
  localparam logic signed [STEP_W-1:0] StepS = STEP_W'(STEP_PER_PIXEL);
  localparam logic signed [EW-1:0] ElevMax = EW'(orbcam_pkg::ELEV_LIMIT);
  localparam logic signed [EW-1:0] ElevMin = -ElevMax;

  // constant quarter-wave table
  logic [16:0] qsin_tab [QE+1];
  for (genvar k = 0; k <= QE; k++) begin : g_tab
    localparam logic [16:0] Val = orbcam_pkg::qsin_entry(k, SINE_TABLE_BITS);
    assign qsin_tab[k] = Val;
  end

  // configuration
  logic signed [31:0] center_q [3];
  logic [21:0]        radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= '0;
      center_q[1] <= '0;
      center_q[2] <= '0;
      radius_q    <= orbcam_pkg::RADIUS_RESET;
    end else if (cfg_we_i) begin
      case (orbcam_pkg::orbcam_reg_e'(cfg_idx_i))
        orbcam_pkg::REG_CENTER_X: center_q[0] <= cfg_wdata_i;
        orbcam_pkg::REG_CENTER_Y: center_q[1] <= cfg_wdata_i;
        orbcam_pkg::REG_CENTER_Z: center_q[2] <= cfg_wdata_i;
        orbcam_pkg::REG_RADIUS:   radius_q    <= cfg_wdata_i[21:0];
        default: ;
      endcase
    end
  end

  // view state update
  logic [15:0]        az_q, az_d;
  logic signed [15:0] el_q, el_d;
  logic [23:0]        dist_q, dist_d;
  logic signed [MW-1:0] dx_step, dy_step;
  logic signed [EW-1:0] el_sum;

  always_comb begin
    dx_step = MW'(delta_x_i) * MW'(StepS);
    dy_step = MW'(delta_y_i) * MW'(StepS);
    el_sum  = EW'(el_q) + EW'(dy_step);
    az_d    = az_q;
    el_d    = el_q;
    dist_d  = dist_q;
    case (orbcam_pkg::orbcam_op_e'(op_i))
      orbcam_pkg::OP_REL: begin
        az_d = az_q - dx_step[15:0];
        if (el_sum > ElevMax) el_d = ElevMax[15:0];
        else if (el_sum < ElevMin) el_d = ElevMin[15:0];
        else el_d = el_sum[15:0];
      end
      orbcam_pkg::OP_ABS: begin
        az_d   = new_azimuth_i;
        el_d   = new_elevation_i;
        dist_d = new_distance_i;
      end
      orbcam_pkg::OP_DIST: dist_d = new_distance_i;
      default: begin
        az_d   = orbcam_pkg::HOME_AZIMUTH;
        el_d   = orbcam_pkg::HOME_ELEVATION;
        dist_d = {radius_q, 2'b00};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_q   <= orbcam_pkg::HOME_AZIMUTH;
      el_q   <= orbcam_pkg::HOME_ELEVATION;
      dist_q <= orbcam_pkg::HOME_DISTANCE;
    end else if (cmd_i.accept) begin
      az_q   <= az_d;
      el_q   <= el_d;
      dist_q <= dist_d;
    end
  end

  // lookups: sin az, cos az, sin el, cos el
  logic [15:0]                     ang [4];
  logic [SINE_TABLE_BITS-1:0]      tidx [4];
  logic [TIW-1:0]                  sel [4];
  logic signed [17:0]              trig_d [4];
  logic signed [17:0]              trig_q [4];

  always_comb begin
    ang[0] = az_q;
    ang[1] = az_q + orbcam_pkg::QUARTER_TURN;
    ang[2] = el_q;
    ang[3] = el_q + orbcam_pkg::QUARTER_TURN;
    for (int i = 0; i < 4; i++) begin
      tidx[i] = ang[i][15 -: SINE_TABLE_BITS];
      if (tidx[i][SINE_TABLE_BITS-2]) begin
        sel[i] = TIW'(QE) - TIW'(tidx[i][SINE_TABLE_BITS-3:0]);
      end else begin
        sel[i] = TIW'(tidx[i][SINE_TABLE_BITS-3:0]);
      end
      trig_d[i] = $signed({1'b0, qsin_tab[sel[i]]});
      if (tidx[i][SINE_TABLE_BITS-1]) trig_d[i] = -trig_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) trig_q <= trig_d;
  end

  // horizontal factors
  function automatic logic signed [17:0] rnd16(logic signed [35:0] v);
    logic [35:0] mag;
    logic [35:0] r;
    mag = v[35] ? 36'(-v) : 36'(v);
    r = (mag + 36'd32768) >> 16;
    return v[35] ? -$signed(r[17:0]) : $signed(r[17:0]);
  endfunction

  function automatic logic signed [34:0] rnd8(logic signed [42:0] v);
    logic [42:0] mag;
    logic [42:0] r;
    mag = v[42] ? 43'(-v) : 43'(v);
    r = (mag + 43'd128) >> 8;
    return v[42] ? -$signed(r[34:0]) : $signed(r[34:0]);
  endfunction

  logic signed [35:0] fx_prod, fz_prod;
  logic signed [17:0] fx_q, fz_q, sb_q;

  assign fx_prod = trig_q[1] * trig_q[3];
  assign fz_prod = trig_q[0] * trig_q[3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.fact) begin
      fx_q <= rnd16(fx_prod);
      fz_q <= rnd16(fz_prod);
      sb_q <= trig_q[2];
    end
  end

  // distance products
  logic signed [24:0] dist_s;
  logic signed [42:0] prod_q [3];
  assign dist_s = $signed({1'b0, dist_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      prod_q[0] <= 43'(dist_s) * 43'(fx_q);
      prod_q[1] <= 43'(dist_s) * 43'(sb_q);
      prod_q[2] <= 43'(dist_s) * 43'(fz_q);
    end
  end

  // subtract from center and saturate
  logic signed [35:0] diff [3];
  logic signed [31:0] pos_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = 36'(center_q[i]) - 36'(rnd8(prod_q[i]));
      if (diff[i] > 36'sd2147483647) pos_d[i] = 32'sh7fffffff;
      else if (diff[i] < -36'sd2147483648) pos_d[i] = 32'sh80000000;
      else pos_d[i] = diff[i][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_x_o         <= pos_d[0];
      pos_y_o         <= pos_d[1];
      pos_z_o         <= pos_d[2];
      cur_azimuth_o   <= az_q;
      cur_elevation_o <= el_q;
      cur_distance_o  <= dist_q;
    end
  end

endmodule

// ----- hw/rtl/orbcam_chk.sv -----
// Orbit camera port checker and its bind to the top level.
// Depends on orbit_camera_position and its interface ports.
module orbcam_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cmd_valid_i,
  input logic        cmd_ready_i,
  input logic        pos_valid_i,
  input logic        pos_ready_i,
  input logic [31:0] pos_x_i,
  input logic [23:0] cur_distance_i
);

  // a stalled result holds its value
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_valid_i && !pos_ready_i |=> pos_valid_i && $stable(pos_x_i)
      && $stable(cur_distance_i))
    else $error("stalled position transaction changed");

  // a command keeps the block busy through its four work steps
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i ##1 !cmd_ready_i
      ##1 !cmd_ready_i ##1 !cmd_ready_i)
    else $error("command taken while busy");

  // a new result only comes out of the sum step, never from idle
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pos_valid_i) |-> !$past(cmd_ready_i))
    else $error("result appeared without a command in flight");

endmodule

bind orbit_camera_position orbcam_chk u_orbcam_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cmd_valid_i    (cmd_i.valid),
  .cmd_ready_i    (cmd_i.ready),
  .pos_valid_i    (pos_o.valid),
  .pos_ready_i    (pos_o.ready),
  .pos_x_i        (pos_o.pos_x),
  .cur_distance_i (pos_o.cur_distance)
);
